@@ rtl/sact_pkg.sv @@
`default_nettype none
package sact_pkg;

	localparam int TAG_W     = 30;
	localparam int ADDR_W    = 32;
	localparam int SET_RAW_W = 7;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	// victim policy codes
	localparam logic [1:0] POL_RANDOM = 2'd0;
	localparam logic [1:0] POL_LRU    = 2'd1;
	localparam logic [1:0] POL_PLRU   = 2'd2;
	localparam logic [1:0] POL_SPARE  = 2'd3;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 2'd2;

	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              opcode;
	} cmd_t;

	typedef struct packed {
		logic             hit;
		logic [1:0]       way;
		logic             write_back;
		logic [TAG_W-1:0] victim_tag;
	} res_t;

	typedef struct packed {
		logic [1:0] replace_policy;
		logic [3:0] offset_bits;
		logic [2:0] index_bits;
	} cfg_t;

	// classified access handed from front to back
	typedef struct packed {
		logic [TAG_W-1:0]     tag;
		logic [SET_RAW_W-1:0] set;
		logic                 opcode;
		logic [1:0]           pol;
	} job_t;

endpackage
`default_nettype wire

@@ rtl/sact_ram.sv @@
`default_nettype none
module sact_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic                                         re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/sact_fifo.sv @@
`default_nettype none
module sact_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sact_pkg::job_t din,
	input  wire logic          pop,
	output sact_pkg::job_t     dout,
	output logic               full,
	output logic               empty
);
	sact_pkg::job_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	assign dout  = slot_q[rp_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
endmodule
`default_nettype wire

@@ rtl/sact_front.sv @@
`default_nettype none
module sact_front #(
	parameter int SETS = 64
) (
	input  wire logic           start,
	input  wire sact_pkg::cmd_t cmd,
	input  wire sact_pkg::cfg_t cfg,
	input  wire logic           q_full,
	input  wire logic           clearing,
	output logic                busy,
	output logic                push,
	output sact_pkg::job_t      job
);
	localparam logic [19:0] SETS_W = 20'(SETS);

	logic [3:0]  off;
	logic [4:0]  sh;
	logic [31:0] tag_sh, set_sh;
	logic [7:0]  mask;
	logic [19:0] r;
	logic [1:0]  pol;

	always_comb begin
		off    = (cfg.offset_bits < 4'd2) ? 4'd2 : cfg.offset_bits;
		sh     = {1'b0, off} + {2'b0, cfg.index_bits};
		tag_sh = cmd.address >> sh;
		set_sh = cmd.address >> off;
		mask   = (8'd1 << cfg.index_bits) - 8'd1;
		r      = {13'b0, set_sh[6:0] & mask[6:0]};
		// set index modulo SETS, restoring compare/subtract
		for (int k = 6; k >= 0; k--) begin
			if (r >= (SETS_W << k)) begin
				r = r - (SETS_W << k);
			end
		end
		pol = (cfg.replace_policy == sact_pkg::POL_SPARE) ? sact_pkg::POL_RANDOM
			: cfg.replace_policy;
		job.tag    = tag_sh[sact_pkg::TAG_W-1:0];
		job.set    = r[sact_pkg::SET_RAW_W-1:0];
		job.opcode = cmd.opcode;
		job.pol    = pol;
	end

	assign busy = clearing | q_full;
	assign push = start & ~busy;
endmodule
`default_nettype wire

@@ rtl/sact_back.sv @@
`default_nettype none
module sact_back #(
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           empty,
	input  wire sact_pkg::job_t head,
	output logic                pop,
	output logic                clearing,
	output logic                done,
	output sact_pkg::res_t      result
);
	localparam int TW      = sact_pkg::TAG_W;
	localparam int SW      = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WB      = $clog2(WAYS);
	localparam int NW      = $clog2(2 * WAYS);
	localparam int FW      = $clog2(WAYS + 1);
	localparam int LV      = $clog2(WAYS) + 1;
	localparam int VAL_LO  = WAYS * TW;
	localparam int DTY_LO  = VAL_LO + WAYS;
	localparam int LRU_LO  = DTY_LO + WAYS;
	localparam int PL_LO   = LRU_LO + WAYS * WB;
	localparam int FILL_LO = PL_LO + WAYS;
	localparam int ROW_W   = FILL_LO + FW;
	localparam int C1      = 16 % WAYS;
	localparam int C2      = 256 % WAYS;
	localparam int C3      = 4096 % WAYS;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_FILL} state_t;

	state_t         state_q;
	logic [SW-1:0]  clr_q;
	sact_pkg::job_t job_q;
	logic           hit_s2;
	logic [WB-1:0]  hway_s2;
	logic [9:0]     lsum_s2;
	logic [15:0]    lfsr_q;
	logic           done_q;
	sact_pkg::res_t res_q;

	logic             we, re;
	logic [SW-1:0]    waddr, raddr;
	logic [ROW_W-1:0] wdata, rdata;

	// row fields
	logic [TW-1:0]   tag_a [WAYS];
	logic [WB-1:0]   lru_a [WAYS];
	logic [WAYS-1:0] val_v, dty_v, pl_v;
	logic [FW-1:0]   fill_v;
	logic [TW-1:0]   tag_n [WAYS];
	logic [WB-1:0]   lru_n [WAYS];
	logic [WAYS-1:0] val_n, dty_n, pl_n, pl_t;
	logic [FW-1:0]   fill_n;

	logic           hit_c, full, inv_found, lfsr_adv, wr, dir, wb_c;
	logic [WB-1:0]  hway_c, inv_way, lmod, tree_way, victim, mv, p;
	logic [9:0]     lsum_c;
	logic [14:0]    r;
	logic [NW-1:0]  node, leaf;
	sact_pkg::res_t res_c;

	sact_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			tag_a[i] = rdata[i*TW +: TW];
			lru_a[i] = rdata[LRU_LO + i*WB +: WB];
		end
		val_v  = rdata[VAL_LO +: WAYS];
		dty_v  = rdata[DTY_LO +: WAYS];
		pl_v   = rdata[PL_LO +: WAYS];
		fill_v = rdata[FILL_LO +: FW];
		wr     = (job_q.opcode == sact_pkg::OP_WRITE);

		// lookup
		hit_c  = 1'b0;
		hway_c = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (val_v[i] && (tag_a[i] == job_q.tag)) begin
				hit_c  = 1'b1;
				hway_c = WB'(i);
			end
		end

		// lfsr mod WAYS: hex digits weighted by 16^i mod WAYS, reduced next cycle
		lsum_c = 10'(lfsr_q[3:0]) + 10'(lfsr_q[7:4] * C1) + 10'(lfsr_q[11:8] * C2)
			+ 10'(lfsr_q[15:12] * C3);
		r = 15'(lsum_s2);
		for (int k = 9; k >= 0; k--) begin
			if (r >= 15'(WAYS << k)) begin
				r = r - 15'(WAYS << k);
			end
		end
		lmod = WB'(r);

		full = (fill_v >= FW'(WAYS));

		// first invalid way in recency order
		inv_found = 1'b0;
		inv_way   = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (!val_v[lru_a[i]]) begin
				inv_found = 1'b1;
				inv_way   = lru_a[i];
			end
		end

		// tree walk, flipping each visited node
		pl_t = pl_v;
		node = NW'(1);
		dir  = 1'b0;
		for (int s = 0; s < LV; s++) begin
			if (node < NW'(WAYS)) begin
				dir                   = pl_t[node[WB-1:0]];
				pl_t[node[WB-1:0]]    = ~dir;
				node                  = NW'({node, dir});
			end
		end
		tree_way = WB'(node - NW'(WAYS));

		lfsr_adv = 1'b0;
		if ((job_q.pol != sact_pkg::POL_PLRU) && !full && inv_found) begin
			victim = inv_way;
		end else begin
			case (job_q.pol)
				sact_pkg::POL_RANDOM: begin
					victim   = lmod;
					lfsr_adv = !hit_s2;
				end
				sact_pkg::POL_LRU: victim = lru_a[WAYS-1];
				default:           victim = tree_way;
			endcase
		end

		// next row
		for (int i = 0; i < WAYS; i++) begin
			tag_n[i] = tag_a[i];
			lru_n[i] = lru_a[i];
		end
		val_n  = val_v;
		dty_n  = dty_v;
		pl_n   = pl_v;
		fill_n = fill_v;
		mv     = hit_s2 ? hway_s2 : victim;
		if (hit_s2) begin
			if (wr) begin
				dty_n[hway_s2] = 1'b1;
			end
			if (job_q.pol == sact_pkg::POL_PLRU) begin
				leaf = NW'(hway_s2) + NW'(WAYS);
				for (int s = 0; s < LV; s++) begin
					if (leaf > NW'(1)) begin
						pl_n[WB'(leaf >> 1)] = ~leaf[0];
						leaf                 = leaf >> 1;
					end
				end
			end
		end else begin
			tag_n[victim] = job_q.tag;
			val_n[victim] = 1'b1;
			dty_n[victim] = wr;
			if (!val_v[victim] && !full) begin
				fill_n = fill_v + FW'(1);
			end
			if (job_q.pol == sact_pkg::POL_PLRU) begin
				pl_n = pl_t;
			end
		end
		leaf = '0;

		// move to front
		p = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (lru_a[i] == mv) begin
				p = WB'(i);
			end
		end
		if (job_q.pol == sact_pkg::POL_LRU) begin
			lru_n[0] = mv;
			for (int i = 1; i < WAYS; i++) begin
				if (WB'(i) <= p) begin
					lru_n[i] = lru_a[i-1];
				end
			end
		end

		wb_c             = !hit_s2 && val_v[victim] && dty_v[victim];
		res_c.hit        = hit_s2;
		res_c.way        = 2'(mv);
		res_c.write_back = wb_c;
		res_c.victim_tag = wb_c ? tag_a[victim] : '0;

		// write row: clear pattern or updated set
		wdata = '0;
		if (state_q == ST_CLEAR) begin
			for (int i = 0; i < WAYS; i++) begin
				wdata[LRU_LO + i*WB +: WB] = WB'(i);
			end
		end else begin
			for (int i = 0; i < WAYS; i++) begin
				wdata[i*TW +: TW]           = tag_n[i];
				wdata[LRU_LO + i*WB +: WB] = lru_n[i];
			end
			wdata[VAL_LO +: WAYS] = val_n;
			wdata[DTY_LO +: WAYS] = dty_n;
			wdata[PL_LO +: WAYS]  = pl_n;
			wdata[FILL_LO +: FW]  = fill_n;
		end
	end

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign re       = pop;
	assign raddr    = SW'(head.set);
	assign we       = (state_q == ST_CLEAR) || (state_q == ST_FILL);
	assign waddr    = (state_q == ST_CLEAR) ? clr_q : SW'(job_q.set);
	assign clearing = (state_q == ST_CLEAR);
	assign done     = done_q;
	assign result   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			lfsr_q  <= 16'h0001;
			done_q  <= 1'b0;
			res_q   <= '0;
			job_q   <= '0;
			hit_s2  <= 1'b0;
			hway_s2 <= '0;
			lsum_s2 <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!empty) begin
						job_q   <= head;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit_s2  <= hit_c;
					hway_s2 <= hway_c;
					lsum_s2 <= lsum_c;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					done_q  <= 1'b1;
					res_q   <= res_c;
					state_q <= ST_IDLE;
					if (lfsr_adv) begin
						lfsr_q <= {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |=> done_q)
		else $error("fill without result strobe");
	a_fill_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> (fill_v <= FW'(WAYS)))
		else $error("fill count above way count");
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.hit) |-> (!res_q.write_back && (res_q.victim_tag == '0)))
		else $error("hit reported an eviction");
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

@@ rtl/set_assoc_cache_tag_controller.sv @@
`default_nettype none
// channel  | ports                          | beat taken when
// ---------+--------------------------------+------------------------------
// access   | start, busy, cmd               | start && !busy at clk rise
// result   | done, result                   | every cycle done is high
// config   | cfg_we, cfg_idx, cfg_data      | cfg_we at clk rise
//
// After reset a clear pass writes every set row, with busy high.
// In the back end each access goes through row read, tag compare and row
// update; the set row is read through a registered port and written back.
// An accepted access waits in the queue, is popped in ST_IDLE, compared in
// ST_LOOK and updated in ST_FILL, which registers done and result.
// A 2-entry queue sits between front and back; busy rises when it is full.
// The result side has no stall.
module set_assoc_cache_tag_controller #(
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire sact_pkg::cmd_t                      cmd,
	output logic                                     done,
	output sact_pkg::res_t                           result,
	input  wire logic                                cfg_we,
	input  wire logic [sact_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [sact_pkg::CFG_W-1:0]          cfg_data
);
	sact_pkg::cfg_t cfg_q;
	sact_pkg::job_t push_job, head_job;
	logic           push, pop, q_full, q_empty, clearing;

	// config registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.replace_policy <= sact_pkg::POL_LRU;
			cfg_q.offset_bits    <= 4'd6;
			cfg_q.index_bits     <= 3'd6;
		end else if (cfg_we) begin
			case (cfg_idx)
				sact_pkg::REG_POLICY: cfg_q.replace_policy <= cfg_data[1:0];
				sact_pkg::REG_OFFSET: cfg_q.offset_bits    <= cfg_data;
				sact_pkg::REG_INDEX:  cfg_q.index_bits     <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// front: decode address into tag/set, normalize policy
	sact_front #(.SETS(SETS)) u_front (
		.start   (start),
		.cmd     (cmd),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.clearing(clearing),
		.busy    (busy),
		.push    (push),
		.job     (push_job)
	);

	sact_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_job),
		.pop   (pop),
		.dout  (head_job),
		.full  (q_full),
		.empty (q_empty)
	);

	// back: per-set row lookup, victim choice, row update
	sact_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.head    (head_job),
		.pop     (pop),
		.clearing(clearing),
		.done    (done),
		.result  (result)
	);
endmodule
`default_nettype wire
